>>> rtl/kmer_strand_vote_unit_assert.svh
// assertion macros shared by the strand vote unit modules
`ifndef KMER_STRAND_VOTE_UNIT_ASSERT_SVH
`define KMER_STRAND_VOTE_UNIT_ASSERT_SVH

// same-cycle implication, checked on every clock while out of reset
`define KSV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ksv assertion failed");

// next-cycle implication
`define KSV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ksv assertion failed");

`endif

>>> rtl/ksv_pkg.sv
// shared constants, codes and types of the strand vote unit
package ksv_pkg;

  localparam int MAX_WORD_LENGTH = 8;
  localparam int COUNT_BITS      = 16;
  localparam int VOTE_BITS       = 16;
  localparam int TOTAL_BITS      = 32;
  localparam int KMER_BITS       = 2 * MAX_WORD_LENGTH;
  localparam int ADDR_BITS       = 16;
  localparam int TABLE_DEPTH     = 1 << ADDR_BITS;
  localparam int LEN_BITS        = 4;
  localparam int RATIO_BITS      = 4;
  localparam int MINV_BITS       = 16;
  localparam int BASE_IDX_BITS   = $clog2(MAX_WORD_LENGTH);
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  localparam logic [1:0] STRAND_FWD  = 2'd0;
  localparam logic [1:0] STRAND_REV  = 2'd1;
  localparam logic [1:0] STRAND_NONE = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WORD_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_KMER_RATIO  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VOTE_RATIO  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_VOTES   = 2'd3;

  localparam logic [LEN_BITS-1:0]   RST_WORD_LENGTH = 4'd8;
  localparam logic [RATIO_BITS-1:0] RST_KMER_RATIO  = 4'd8;
  localparam logic [RATIO_BITS-1:0] RST_VOTE_RATIO  = 4'd4;
  localparam logic [MINV_BITS-1:0]  RST_MIN_VOTES   = 16'd1;

  typedef struct packed {
    logic [LEN_BITS-1:0]   word_length;
    logic [RATIO_BITS-1:0] kmer_ratio;
    logic [RATIO_BITS-1:0] vote_ratio;
    logic [MINV_BITS-1:0]  min_votes;
  } cfg_t;

  typedef struct packed {
    logic                  load;
    logic                  vote;
    logic                  close;
    logic [ADDR_BITS-1:0]  fwd_addr;
    logic [ADDR_BITS-1:0]  rev_addr;
    logic [COUNT_BITS-1:0] count;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> rtl/kmer_strand_vote_unit.sv
// top level of the k-mer strand vote unit: configuration registers, front end, queue, back end
//
// input channel: in_valid/in_stall, one beat per item (mode, kmer, count_value, last).
// load beats write count_value into the count table at address kmer; query beats carry
// one k-mer; the query's last k-mer, or a close beat, produces one result beat.
// output channel: out_valid/out_stall carrying strand, the query's votes and the
// running saturating totals of forward, reverse and undetermined queries.
// throughput: one input beat per cycle, sustained while in_stall is low, loads and queries mixed freely;
// the table is a dual-port memory read at the forward and reverse address together.
// a closing beat passes the queue write, table read, vote, accumulate and decide
// steps in that order before out_valid rises.
// configuration: cfg_write/cfg_index/cfg_data, taken at the edge where cfg_write is high.
// reset: clears the vote accumulators, totals, queue and pipeline and restores the
// register defaults; the count table keeps its contents and must be loaded before use.
// receiver stall: the held result stays on the output, the back end freezes, the
// four-entry queue keeps taking beats and in_stall rises once it is full.
module kmer_strand_vote_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           mode,
  input  logic [ksv_pkg::KMER_BITS-1:0]        kmer,
  input  logic [ksv_pkg::COUNT_BITS-1:0]       count_value,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           strand,
  output logic [ksv_pkg::VOTE_BITS-1:0]        forward_votes,
  output logic [ksv_pkg::VOTE_BITS-1:0]        reverse_votes,
  output logic [ksv_pkg::TOTAL_BITS-1:0]       forward_total,
  output logic [ksv_pkg::TOTAL_BITS-1:0]       reverse_total,
  output logic [ksv_pkg::TOTAL_BITS-1:0]       unmatched_total,
  input  logic                                 cfg_write,
  input  logic [ksv_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ksv_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import ksv_pkg::*;

  cfg_t   cfg;
  qent_t  front_entry;
  qent_t  q_entry;
  qstat_t q_status;
  logic   front_keep;
  logic   push;
  logic   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.word_length <= RST_WORD_LENGTH;
      cfg.kmer_ratio  <= RST_KMER_RATIO;
      cfg.vote_ratio  <= RST_VOTE_RATIO;
      cfg.min_votes   <= RST_MIN_VOTES;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WORD_LENGTH: cfg.word_length <= cfg_data[LEN_BITS-1:0];
        CFG_KMER_RATIO:  cfg.kmer_ratio  <= cfg_data[RATIO_BITS-1:0];
        CFG_VOTE_RATIO:  cfg.vote_ratio  <= cfg_data[RATIO_BITS-1:0];
        CFG_MIN_VOTES:   cfg.min_votes   <= cfg_data[MINV_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_status.full;
  // beats of the unused mode are taken and dropped
  assign push     = in_valid && !q_status.full && front_keep;

  ksv_front u_front (
    .mode        (mode),
    .kmer        (kmer),
    .count_value (count_value),
    .last        (last),
    .word_length (cfg.word_length),
    .entry       (front_entry),
    .keep        (front_keep)
  );

  ksv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (front_entry),
    .pop      (pop),
    .rd_entry (q_entry),
    .status   (q_status)
  );

  ksv_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (!q_status.empty),
    .q_entry         (q_entry),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .strand          (strand),
    .forward_votes   (forward_votes),
    .reverse_votes   (reverse_votes),
    .forward_total   (forward_total),
    .reverse_total   (reverse_total),
    .unmatched_total (unmatched_total)
  );

endmodule

>>> rtl/ksv_front.sv
// front end: classifies input beats and forms the masked k-mer and its reverse complement
module ksv_front (
  input  logic [1:0]                   mode,
  input  logic [ksv_pkg::KMER_BITS-1:0] kmer,
  input  logic [ksv_pkg::COUNT_BITS-1:0] count_value,
  input  logic                         last,
  input  logic [ksv_pkg::LEN_BITS-1:0] word_length,
  output ksv_pkg::qent_t               entry,
  output logic                         keep
);
  import ksv_pkg::*;

  logic [LEN_BITS-1:0]      len;
  logic [BASE_IDX_BITS-1:0] idx;
  logic [KMER_BITS-1:0]     fk;
  logic [KMER_BITS-1:0]     rk;

  always_comb begin
    if (word_length == '0) begin
      len = LEN_BITS'(1);
    end else if (word_length > LEN_BITS'(MAX_WORD_LENGTH)) begin
      len = LEN_BITS'(MAX_WORD_LENGTH);
    end else begin
      len = word_length;
    end
  end

  // base j of the result is the complement of base len-1-j of the input
  always_comb begin
    idx = '0;
    fk  = '0;
    rk  = '0;
    for (int j = 0; j < MAX_WORD_LENGTH; j++) begin
      if (LEN_BITS'(j) < len) begin
        idx = BASE_IDX_BITS'(len - LEN_BITS'(j) - LEN_BITS'(1));
        fk[2*j +: 2] = kmer[2*j +: 2];
        rk[2*j +: 2] = ~kmer[{idx, 1'b0} +: 2];
      end
    end
  end

  // mode three is dropped here, last only counts on query beats
  assign keep           = (mode != 2'd3);
  assign entry.load     = (mode == MODE_LOAD);
  assign entry.vote     = (mode == MODE_QUERY);
  assign entry.close    = ((mode == MODE_QUERY) && last) || (mode == MODE_CLOSE);
  assign entry.fwd_addr = (mode == MODE_LOAD) ? ADDR_BITS'(kmer) : ADDR_BITS'(fk);
  assign entry.rev_addr = ADDR_BITS'(rk);
  assign entry.count    = count_value;

endmodule

>>> rtl/ksv_queue.sv
// short fifo between the front end and the table/vote back end
module ksv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ksv_pkg::qent_t wr_entry,
  input  logic           pop,
  output ksv_pkg::qent_t rd_entry,
  output ksv_pkg::qstat_t status
);
  import ksv_pkg::*;

  qent_t                store [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  assign rd_entry     = store[rd_ptr];
  assign status.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

`include "kmer_strand_vote_unit_assert.svh"

  `KSV_ASSERT_IMP(a_no_push_full, push, !status.full)
  `KSV_ASSERT_IMP(a_no_pop_empty, pop, !status.empty)
  `KSV_ASSERT_NXT(a_pop_drains, (pop && !push), (count == ($past(count) - QCNT_BITS'(1))))

endmodule

>>> rtl/ksv_back.sv
// back end: count table, per-k-mer vote, vote accumulators, strand decision and totals
module ksv_back (
  input  logic                             clk,
  input  logic                             rst,
  input  ksv_pkg::cfg_t                    cfg,
  input  logic                             q_valid,
  input  ksv_pkg::qent_t                   q_entry,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       strand,
  output logic [ksv_pkg::VOTE_BITS-1:0]    forward_votes,
  output logic [ksv_pkg::VOTE_BITS-1:0]    reverse_votes,
  output logic [ksv_pkg::TOTAL_BITS-1:0]   forward_total,
  output logic [ksv_pkg::TOTAL_BITS-1:0]   reverse_total,
  output logic [ksv_pkg::TOTAL_BITS-1:0]   unmatched_total
);
  import ksv_pkg::*;

  localparam int HPROD_BITS = COUNT_BITS + RATIO_BITS;
  localparam int VPROD_BITS = VOTE_BITS + RATIO_BITS;

  localparam logic [1:0] VOTE_NONE = 2'd0;
  localparam logic [1:0] VOTE_FWD  = 2'd1;
  localparam logic [1:0] VOTE_REV  = 2'd2;

  localparam logic [VOTE_BITS-1:0]  VOTE_MAX  = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  logic                  adv;

  logic [COUNT_BITS-1:0] table_mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] hit_f;
  logic [COUNT_BITS-1:0] hit_r;

  logic                  s1_valid;
  logic                  s1_vote;
  logic                  s1_close;

  logic [HPROD_BITS-1:0] lim_f;
  logic [HPROD_BITS-1:0] lim_r;
  logic [1:0]            vote_code;

  logic                  s2_valid;
  logic                  s2_close;
  logic [1:0]            s2_vote;

  logic [VOTE_BITS-1:0]  fwd_acc;
  logic [VOTE_BITS-1:0]  rev_acc;
  logic [VOTE_BITS-1:0]  fwd_acc_next;
  logic [VOTE_BITS-1:0]  rev_acc_next;

  logic                  s3_valid;
  logic [VOTE_BITS-1:0]  s3_fv;
  logic [VOTE_BITS-1:0]  s3_rv;

  logic [VPROD_BITS-1:0] need_f;
  logic [VPROD_BITS-1:0] need_r;
  logic                  fwd_ok;
  logic                  rev_ok;

  // the whole back end freezes while a result waits on a stalled receiver
  assign adv = !out_valid || !out_stall;
  assign pop = adv && q_valid;

  // table: one write port for loads, two registered read ports for queries
  always_ff @(posedge clk) begin
    if (pop && q_entry.load) begin
      table_mem[q_entry.fwd_addr] <= q_entry.count;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_f <= table_mem[q_entry.fwd_addr];
      hit_r <= table_mem[q_entry.rev_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pop && (q_entry.vote || q_entry.close);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_vote  <= q_entry.vote;
      s1_close <= q_entry.close;
    end
  end

  // per-k-mer vote
  assign lim_f = HPROD_BITS'(cfg.kmer_ratio) * HPROD_BITS'(hit_r);
  assign lim_r = HPROD_BITS'(cfg.kmer_ratio) * HPROD_BITS'(hit_f);

  always_comb begin
    priority if (!s1_vote) begin
      vote_code = VOTE_NONE;
    end else if (HPROD_BITS'(hit_f) > lim_f) begin
      vote_code = VOTE_FWD;
    end else if (HPROD_BITS'(hit_r) > lim_r) begin
      vote_code = VOTE_REV;
    end else begin
      vote_code = VOTE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_close <= s1_close;
      s2_vote  <= vote_code;
    end
  end

  // saturating vote accumulators
  always_comb begin
    fwd_acc_next = fwd_acc;
    rev_acc_next = rev_acc;
    if ((s2_vote == VOTE_FWD) && (fwd_acc != VOTE_MAX)) begin
      fwd_acc_next = fwd_acc + VOTE_BITS'(1);
    end
    if ((s2_vote == VOTE_REV) && (rev_acc != VOTE_MAX)) begin
      rev_acc_next = rev_acc + VOTE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_acc  <= '0;
      rev_acc  <= '0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid && s2_close;
      if (s2_valid) begin
        if (s2_close) begin
          fwd_acc <= '0;
          rev_acc <= '0;
        end else begin
          fwd_acc <= fwd_acc_next;
          rev_acc <= rev_acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fv <= fwd_acc_next;
      s3_rv <= rev_acc_next;
    end
  end

  // strand decision on the closed query
  assign need_f = VPROD_BITS'(cfg.vote_ratio) * VPROD_BITS'(s3_rv);
  assign need_r = VPROD_BITS'(cfg.vote_ratio) * VPROD_BITS'(s3_fv);
  assign fwd_ok = (32'(s3_fv) >= 32'(cfg.min_votes)) && (VPROD_BITS'(s3_fv) >= need_f);
  assign rev_ok = (32'(s3_rv) >= 32'(cfg.min_votes)) && (VPROD_BITS'(s3_rv) >= need_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      forward_total   <= '0;
      reverse_total   <= '0;
      unmatched_total <= '0;
    end else if (adv) begin
      out_valid <= s3_valid;
      if (s3_valid) begin
        priority if (fwd_ok) begin
          if (forward_total != TOTAL_MAX) begin
            forward_total <= forward_total + TOTAL_BITS'(1);
          end
        end else if (rev_ok) begin
          if (reverse_total != TOTAL_MAX) begin
            reverse_total <= reverse_total + TOTAL_BITS'(1);
          end
        end else begin
          if (unmatched_total != TOTAL_MAX) begin
            unmatched_total <= unmatched_total + TOTAL_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid) begin
      forward_votes <= s3_fv;
      reverse_votes <= s3_rv;
      priority if (fwd_ok) begin
        strand <= STRAND_FWD;
      end else if (rev_ok) begin
        strand <= STRAND_REV;
      end else begin
        strand <= STRAND_NONE;
      end
    end
  end

`include "kmer_strand_vote_unit_assert.svh"

  `KSV_ASSERT_NXT(a_stall_holds_acc, (out_valid && out_stall), ($stable(fwd_acc) && $stable(rev_acc)))
  `KSV_ASSERT_NXT(a_close_reaches_out, (s3_valid && adv), out_valid)
  `KSV_ASSERT_IMP(a_fwd_counted, (out_valid && (strand == STRAND_FWD)), (forward_total != '0))
  `KSV_ASSERT_IMP(a_rev_counted, (out_valid && (strand == STRAND_REV)), (reverse_total != '0))

endmodule
